// ===== sv/accel_gesture_detector_assert.svh =====
// assertion macros for the gesture detector
// expects clk and arst_n in the scope of the including module
`ifndef ACCEL_GESTURE_DETECTOR_ASSERT_SVH
`define ACCEL_GESTURE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define AGD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gesture detector check failed");

// next-cycle implication
`define AGD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gesture detector check failed");

`endif

// ===== sv/agd_pkg.sv =====
// types and constants for the accelerometer gesture detector
// no dependencies
package agd_pkg;

	localparam int unsigned LEVEL_W   = 15;
	localparam int unsigned HOLDOFF_W = 16;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 16;

	typedef enum logic [1:0] {
		SIGN_ZERO = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SIGN_THRESHOLD  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_PEAK      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLICK_THRESHOLD = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_HIGH_LEVEL = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LOW_LEVEL  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_HOLDOFF   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FLICK_HOLDOFF   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_HOLDOFF    = 4'd7;

	localparam logic [LEVEL_W-1:0]   RST_SIGN_THRESHOLD  = 15'd3277;
	localparam logic [LEVEL_W-1:0]   RST_SHAKE_PEAK      = 15'd16384;
	localparam logic [LEVEL_W-1:0]   RST_FLICK_THRESHOLD = 15'd20480;
	localparam logic [LEVEL_W-1:0]   RST_STEP_HIGH_LEVEL = 15'd11469;
	localparam logic [LEVEL_W-1:0]   RST_STEP_LOW_LEVEL  = 15'd9011;
	localparam logic [HOLDOFF_W-1:0] RST_SHAKE_HOLDOFF   = 16'd600;
	localparam logic [HOLDOFF_W-1:0] RST_FLICK_HOLDOFF   = 16'd400;
	localparam logic [HOLDOFF_W-1:0] RST_STEP_HOLDOFF    = 16'd350;

endpackage

// ===== sv/accel_gesture_detector.sv =====
// accelerometer gesture detector: shake, flick and step events from timed polls
// depends on agd_pkg and accel_gesture_detector_assert.svh
//
// usage
//   input channel: in_valid / in_stall carry one poll request (now_ms, sensor_ok,
//   sample_valid, accel_x, accel_z). output channel: out_valid / out_stall carry
//   one result request (shake_event, flick_event, step_event) for every poll,
//   all zero for a poll that is ignored.
//   the result is registered: it is in the output register in the cycle after
//   the poll is taken. throughput: one poll per cycle while out_stall is low,
//   set by the single output register, refilled on the edge its result is taken.
//   the sign history is a shift line, newest first, so reversal flags come from
//   fixed neighbour pairs and are counted in the same cycle.
//   configuration: cfg_we with cfg_index and cfg_data writes one threshold or
//   holdoff register; unknown indexes are dropped. write only while idle.
//   reset: all thresholds take their defaults, the history clears to zero sign,
//   all timestamps clear to zero and the output register empties.
//   stall: while out_stall holds a waiting result, in_stall rises and the result
//   and all detector state hold; no poll is lost.
module accel_gesture_detector #(
	parameter int HISTORY_DEPTH    = 8,
	parameter int MIN_REVERSALS    = 4,
	parameter int POLL_INTERVAL_MS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [31:0]                    now_ms,
	input  logic                           sensor_ok,
	input  logic                           sample_valid,
	input  logic signed [15:0]             accel_x,
	input  logic signed [15:0]             accel_z,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           shake_event,
	output logic                           flick_event,
	output logic                           step_event,
	input  logic                           cfg_we,
	input  logic [agd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [agd_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import agd_pkg::*;

	localparam int CNT_W = $clog2(HISTORY_DEPTH);

	logic [LEVEL_W-1:0]   sign_thr_q, shake_peak_q, flick_thr_q, step_hi_q, step_lo_q;
	logic [HOLDOFF_W-1:0] shake_hold_q, flick_hold_q, step_hold_q;

	sign_t       hist_q [HISTORY_DEPTH];
	sign_t       hist_d [HISTORY_DEPTH];
	logic [31:0] last_accept_q, last_shake_q, last_flick_q, last_step_q;
	logic        step_high_q;

	logic        out_valid_q, shake_q, flick_q, step_q;

	logic        accept, taken, poll_ok, sample_ok;
	sign_t       sign_new;
	logic [HISTORY_DEPTH-2:0] rev;
	logic [CNT_W-1:0]         rev_cnt;
	logic signed [16:0] x_ext, z_ext, thr_ext;
	logic [16:0]        mag;
	logic        shake_hit, flick_hit, step_rise, step_fall, step_hit;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign taken    = out_valid_q && !out_stall;

	assign poll_ok   = sensor_ok && ((now_ms - last_accept_q) >= 32'(POLL_INTERVAL_MS));
	assign sample_ok = poll_ok && sample_valid;

	assign x_ext   = 17'(accel_x);
	assign z_ext   = 17'(accel_z);
	assign thr_ext = $signed({2'b00, sign_thr_q});
	assign mag     = accel_x[15] ? 17'(-x_ext) : 17'(x_ext);

	always_comb begin
		if (x_ext > thr_ext) begin
			sign_new = SIGN_POS;
		end else if (x_ext < -thr_ext) begin
			sign_new = SIGN_NEG;
		end else begin
			sign_new = SIGN_ZERO;
		end
	end

	// history after this sample, newest at index zero
	always_comb begin
		hist_d[0] = sign_new;
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			hist_d[i] = hist_q[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
			rev[i] = (hist_d[i] != SIGN_ZERO) && (hist_d[i+1] != SIGN_ZERO) &&
				(hist_d[i] != hist_d[i+1]);
		end
	end

	assign rev_cnt = CNT_W'($countones(rev));

	assign shake_hit = sample_ok &&
		({{(32-CNT_W){1'b0}}, rev_cnt} >= 32'(MIN_REVERSALS)) &&
		(mag > {2'b00, shake_peak_q}) &&
		((now_ms - last_shake_q) > {16'd0, shake_hold_q});

	assign flick_hit = sample_ok && (x_ext > $signed({2'b00, flick_thr_q})) &&
		((now_ms - last_flick_q) > {16'd0, flick_hold_q});

	assign step_rise = sample_ok && !step_high_q && (z_ext > $signed({2'b00, step_hi_q}));
	assign step_fall = sample_ok && step_high_q && (z_ext < $signed({2'b00, step_lo_q}));
	assign step_hit  = step_rise && ((now_ms - last_step_q) > {16'd0, step_hold_q});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_thr_q   <= RST_SIGN_THRESHOLD;
			shake_peak_q <= RST_SHAKE_PEAK;
			flick_thr_q  <= RST_FLICK_THRESHOLD;
			step_hi_q    <= RST_STEP_HIGH_LEVEL;
			step_lo_q    <= RST_STEP_LOW_LEVEL;
			shake_hold_q <= RST_SHAKE_HOLDOFF;
			flick_hold_q <= RST_FLICK_HOLDOFF;
			step_hold_q  <= RST_STEP_HOLDOFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIGN_THRESHOLD:  sign_thr_q   <= cfg_data[LEVEL_W-1:0];
				CFG_SHAKE_PEAK:      shake_peak_q <= cfg_data[LEVEL_W-1:0];
				CFG_FLICK_THRESHOLD: flick_thr_q  <= cfg_data[LEVEL_W-1:0];
				CFG_STEP_HIGH_LEVEL: step_hi_q    <= cfg_data[LEVEL_W-1:0];
				CFG_STEP_LOW_LEVEL:  step_lo_q    <= cfg_data[LEVEL_W-1:0];
				CFG_SHAKE_HOLDOFF:   shake_hold_q <= cfg_data[HOLDOFF_W-1:0];
				CFG_FLICK_HOLDOFF:   flick_hold_q <= cfg_data[HOLDOFF_W-1:0];
				CFG_STEP_HOLDOFF:    step_hold_q  <= cfg_data[HOLDOFF_W-1:0];
				default: ;
			endcase
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= SIGN_ZERO;
			end
			last_accept_q <= '0;
			last_shake_q  <= '0;
			last_flick_q  <= '0;
			last_step_q   <= '0;
			step_high_q   <= 1'b0;
		end else if (accept) begin
			if (poll_ok) begin
				last_accept_q <= now_ms;
			end
			if (sample_ok) begin
				for (int i = 0; i < HISTORY_DEPTH; i++) begin
					hist_q[i] <= hist_d[i];
				end
			end
			if (shake_hit) begin
				last_shake_q <= now_ms;
			end
			if (flick_hit) begin
				last_flick_q <= now_ms;
			end
			if (step_hit) begin
				last_step_q <= now_ms;
			end
			if (step_rise) begin
				step_high_q <= 1'b1;
			end else if (step_fall) begin
				step_high_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shake_q <= shake_hit;
			flick_q <= flick_hit;
			step_q  <= step_hit;
		end
	end

	assign out_valid   = out_valid_q;
	assign shake_event = shake_q;
	assign flick_event = flick_q;
	assign step_event  = step_q;

`include "accel_gesture_detector_assert.svh"

	`AGD_ASSERT_IMP(a_empty_accepts, in_valid && !out_valid_q, !in_stall)
	`AGD_ASSERT_NEXT(a_absent_quiet, accept && !sensor_ok,
		out_valid_q && !shake_q && !flick_q && !step_q)
	`AGD_ASSERT_IMP(a_step_level, out_valid_q && step_q, step_high_q)
	`AGD_ASSERT_IMP(a_flick_time, out_valid_q && flick_q, last_flick_q == last_accept_q)

endmodule
